FILE: design/npg_pkg.sv
`timescale 1ns / 1ps

package npg_pkg;

  localparam int MAX_LEN_DEF = 8;

  localparam int LEN_W  = 4;
  localparam int ELEM_W = 4;
  localparam int POS_W  = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = 4'd4;

  typedef struct packed {
    logic init;
    logic we;
  } npg_wr_t;

endpackage

FILE: design/npg_store.sv
`timescale 1ns / 1ps

module npg_store #(
  parameter int MAX_LEN = npg_pkg::MAX_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  npg_pkg::npg_wr_t               wr,
  input  logic [$clog2(MAX_LEN)-1:0]     waddr,
  input  logic [$clog2(MAX_LEN+1)-1:0]   wdata,
  input  logic [$clog2(MAX_LEN)-1:0]     raddr,
  output logic [$clog2(MAX_LEN+1)-1:0]   rdata
);

  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] mem_r [MAX_LEN];

  always_ff @(posedge clk) begin
    if (!rst_n || wr.init) begin
      for (int k = 0; k < MAX_LEN; k++) begin
        mem_r[k] <= CW'(k + 1);
      end
    end else if (wr.we) begin
      mem_r[waddr] <= wdata;
    end
  end

  assign rdata = mem_r[raddr];

endmodule

FILE: design/next_permutation_generator.sv
`timescale 1ns / 1ps
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  in_restart
// out      output     out_valid/out_stall out_element, out_position, out_last_of_perm,
//                                        out_final_perm, out_exhausted
// cfg      input      cfg_valid/cfg_ready cfg_data (perm_length)
//
// A restart reloads the identity; a request after the last permutation yields an
// exhausted result; other requests scan for the pivot, emit, then, unless final, find the
// ceiling, swap and reverse the suffix, using one comparator and one store read port.
// Synchronous active-low reset loads the identity permutation and perm_length 4.
// Output stalls hold the emit sequence; in_stall is high whenever state is not idle.

module next_permutation_generator #(
  parameter int MAX_LEN = npg_pkg::MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_restart,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [npg_pkg::ELEM_W-1:0] out_element,
  output logic [npg_pkg::POS_W-1:0]  out_position,
  output logic                       out_last_of_perm,
  output logic                       out_final_perm,
  output logic                       out_exhausted,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [npg_pkg::LEN_W-1:0]  cfg_data
);

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PIVOT = 8'b0000_0010,
    S_EMIT  = 8'b0000_0100,
    S_EXH   = 8'b0000_1000,
    S_CEIL  = 8'b0001_0000,
    S_SWAP  = 8'b0010_0000,
    S_REVA  = 8'b0100_0000,
    S_REVB  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [npg_pkg::LEN_W-1:0] cfg_len_r;
  logic                      done_r, done_nxt;
  logic                      final_r, final_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic [IW-1:0]             k_r, k_nxt;
  logic [IW-1:0]             e_r, e_nxt;
  logic [IW-1:0]             piv_r, piv_nxt;
  logic [IW-1:0]             i_r, i_nxt;
  logic [IW-1:0]             j_r, j_nxt;
  logic [CW-1:0]             prev_r, prev_nxt;
  logic [CW-1:0]             pivval_r, pivval_nxt;
  logic [CW-1:0]             tmp_r, tmp_nxt;

  logic                       out_valid_r;
  logic [npg_pkg::ELEM_W-1:0] out_element_r, out_element_nxt;
  logic [npg_pkg::POS_W-1:0]  out_position_r, out_position_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_final_r, out_final_nxt;
  logic                       out_exh_r, out_exh_nxt;
  logic                       out_load;
  logic                       out_free;

  npg_pkg::npg_wr_t st_wr;
  logic [IW-1:0]    st_waddr;
  logic [CW-1:0]    st_wdata;
  logic [IW-1:0]    st_raddr;
  logic [CW-1:0]    st_rdata;

  logic [CW-1:0] cmp_a, cmp_b;
  logic          cmp_lt;

  logic [CW-1:0] n_comb;
  logic [IW-1:0] n_last;
  logic          in_accept;

  npg_store #(
    .MAX_LEN(MAX_LEN)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (st_wr),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign cmp_lt = (cmp_a < cmp_b);

  always_comb begin
    if (cfg_len_r == '0) begin
      n_comb = CW'(1);
    end else if (32'(cfg_len_r) > MAX_LEN) begin
      n_comb = CW'(MAX_LEN);
    end else begin
      n_comb = CW'(cfg_len_r);
    end
  end

  assign n_last    = IW'(n_r - CW'(1));
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt        = state_r;
    done_nxt         = done_r;
    final_nxt        = final_r;
    n_nxt            = n_r;
    k_nxt            = k_r;
    e_nxt            = e_r;
    piv_nxt          = piv_r;
    i_nxt            = i_r;
    j_nxt            = j_r;
    prev_nxt         = prev_r;
    pivval_nxt       = pivval_r;
    tmp_nxt          = tmp_r;
    st_wr            = '0;
    st_waddr         = k_r;
    st_wdata         = pivval_r;
    st_raddr         = k_r;
    cmp_a            = st_rdata;
    cmp_b            = prev_r;
    out_load         = 1'b0;
    out_element_nxt  = out_element_r;
    out_position_nxt = out_position_r;
    out_last_nxt     = out_last_r;
    out_final_nxt    = out_final_r;
    out_exh_nxt      = out_exh_r;

    case (state_r)
      S_IDLE: begin
        st_raddr = IW'(n_comb - CW'(1));
        if (in_accept) begin
          if (in_restart) begin
            st_wr.init = 1'b1;
            done_nxt   = 1'b0;
          end else if (done_r) begin
            state_nxt = S_EXH;
          end else begin
            n_nxt = n_comb;
            e_nxt = '0;
            if (n_comb == CW'(1)) begin
              final_nxt = 1'b1;
              state_nxt = S_EMIT;
            end else begin
              prev_nxt  = st_rdata;
              k_nxt     = IW'(n_comb - CW'(2));
              state_nxt = S_PIVOT;
            end
          end
        end
      end

      S_PIVOT: begin
        st_raddr = k_r;
        cmp_a    = st_rdata;
        cmp_b    = prev_r;
        if (cmp_lt) begin
          piv_nxt    = k_r;
          pivval_nxt = st_rdata;
          final_nxt  = 1'b0;
          state_nxt  = S_EMIT;
        end else begin
          prev_nxt = st_rdata;
          if (k_r == '0) begin
            final_nxt = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            k_nxt = k_r - IW'(1);
          end
        end
      end

      S_EMIT: begin
        st_raddr = e_r;
        if (out_free) begin
          out_load         = 1'b1;
          out_element_nxt  = npg_pkg::ELEM_W'(st_rdata);
          out_position_nxt = npg_pkg::POS_W'(e_r);
          out_last_nxt     = (e_r == n_last);
          out_final_nxt    = final_r;
          out_exh_nxt      = 1'b0;
          if (e_r == n_last) begin
            if (final_r) begin
              done_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              k_nxt     = n_last;
              state_nxt = S_CEIL;
            end
          end else begin
            e_nxt = e_r + IW'(1);
          end
        end
      end

      S_EXH: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_element_nxt  = '0;
          out_position_nxt = '0;
          out_last_nxt     = 1'b1;
          out_final_nxt    = 1'b0;
          out_exh_nxt      = 1'b1;
          state_nxt        = S_IDLE;
        end
      end

      S_CEIL: begin
        st_raddr = k_r;
        cmp_a    = pivval_r;
        cmp_b    = st_rdata;
        if (cmp_lt) begin
          st_wr.we  = 1'b1;
          st_waddr  = k_r;
          st_wdata  = pivval_r;
          tmp_nxt   = st_rdata;
          state_nxt = S_SWAP;
        end else begin
          k_nxt = k_r - IW'(1);
        end
      end

      S_SWAP: begin
        st_wr.we = 1'b1;
        st_waddr = piv_r;
        st_wdata = tmp_r;
        st_raddr = piv_r + IW'(1);
        i_nxt    = piv_r + IW'(1);
        j_nxt    = n_last;
        if ((piv_r + IW'(1)) < n_last) begin
          tmp_nxt   = st_rdata;
          state_nxt = S_REVA;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_REVA: begin
        st_raddr  = j_r;
        st_wr.we  = 1'b1;
        st_waddr  = i_r;
        st_wdata  = st_rdata;
        state_nxt = S_REVB;
      end

      S_REVB: begin
        st_wr.we = 1'b1;
        st_waddr = j_r;
        st_wdata = tmp_r;
        st_raddr = i_r + IW'(1);
        i_nxt    = i_r + IW'(1);
        j_nxt    = j_r - IW'(1);
        if ((i_r + IW'(1)) < (j_r - IW'(1))) begin
          tmp_nxt   = st_rdata;
          state_nxt = S_REVA;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_len_r   <= npg_pkg::LEN_RESET;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_len_r <= cfg_data;
      end
      if (out_free) begin
        out_valid_r <= out_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    final_r  <= final_nxt;
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    e_r      <= e_nxt;
    piv_r    <= piv_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    prev_r   <= prev_nxt;
    pivval_r <= pivval_nxt;
    tmp_r    <= tmp_nxt;
    if (out_load) begin
      out_element_r  <= out_element_nxt;
      out_position_r <= out_position_nxt;
      out_last_r     <= out_last_nxt;
      out_final_r    <= out_final_nxt;
      out_exh_r      <= out_exh_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_element      = out_element_r;
  assign out_position     = out_position_r;
  assign out_last_of_perm = out_last_r;
  assign out_final_perm   = out_final_r;
  assign out_exhausted    = out_exh_r;

  a_done_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> (out_valid_r && out_final_r && out_last_r))
    else $error("done set without a final last result loaded");

  a_exh_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_exh_r) |->
      (out_element_r == '0 && out_last_r && !out_final_r && out_position_r == '0))
    else $error("exhausted result malformed");

  a_ceil_right_of_pivot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CEIL) |-> (k_r > piv_r))
    else $error("ceiling search passed the pivot");

  a_rev_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REVA) |-> (i_r < j_r))
    else $error("suffix reversal indices crossed");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_restart) |=> !done_r)
    else $error("restart did not clear exhausted state");

endmodule
